@@ design/rrw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the reorder receive window.
// No dependencies; imported by every module of the block.
package rrw_pkg;

    localparam int SEQ_W       = 5;
    localparam int LEN_W       = 11;
    localparam int REF_W       = 32;
    localparam int WIN_W       = 5;
    localparam int SEQ_SPACE   = 32;
    localparam int MAX_PAYLOAD = 1024;

    localparam int S_DATA_W = ((SEQ_W + LEN_W + REF_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((SEQ_W + LEN_W + REF_W + 7) / 8) * 8;

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);
    localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_PAYLOAD);

    // Result kinds carried on tuser.
    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;   // capture the accepted packet
        logic store;     // write the packet into its slot and set its flag
        logic deliver;   // emit the head slot, clear it, advance next expected
        logic ack;       // emit the cumulative ack
    } rrw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_window; // the offered packet lies inside the window
        logic head_held; // the slot at next expected holds a packet
        logic out_free;  // the output register can take a result this cycle
    } rrw_stat_t;

endpackage

@@ design/rrw_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing controller of the reorder receive window.
// Depends on rrw_pkg for the command and status types.
module rrw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rrw_pkg::rrw_stat_t stat,
    output rrw_pkg::rrw_cmd_t  cmd
);
    import rrw_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_STORE   = 4'b0010,
        ST_FETCH   = 4'b0100,
        ST_DELIVER = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                // Packets outside the window are taken and dropped here.
                if (s_tvalid && stat.in_window) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                state_next = ST_DELIVER;
            end
            ST_DELIVER: begin
                if (stat.out_free) begin
                    if (stat.head_held) begin
                        cmd.deliver = 1'b1;
                    end else begin
                        cmd.ack    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/rrw_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the reorder receive window: window register, slot store,
// received flags, next-expected counter and output register. Uses rrw_pkg.
module rrw_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [rrw_pkg::WIN_W-1:0]   cfg_data,
    input  logic [rrw_pkg::SEQ_W-1:0]   s_seq,
    input  logic [rrw_pkg::LEN_W-1:0]   s_len,
    input  logic [rrw_pkg::REF_W-1:0]   s_ref,
    input  rrw_pkg::rrw_cmd_t           cmd,
    output rrw_pkg::rrw_stat_t          stat,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic                        m_kind,
    output logic [rrw_pkg::SEQ_W-1:0]   m_seq,
    output logic [rrw_pkg::LEN_W-1:0]   m_len,
    output logic [rrw_pkg::REF_W-1:0]   m_ref,
    output logic                        m_last
);
    import rrw_pkg::*;

    logic [WIN_W-1:0] window_reg;
    logic [SEQ_W-1:0] next_exp_reg;
    logic [SEQ_W-1:0] next_exp_next;
    logic [SEQ_SPACE-1:0] flags_reg;

    logic [SEQ_W-1:0] in_seq_reg;
    logic [LEN_W-1:0] in_len_reg;
    logic [REF_W-1:0] in_ref_reg;

    logic [LEN_W-1:0] held_len_mem [SEQ_SPACE];
    logic [REF_W-1:0] held_ref_mem [SEQ_SPACE];
    logic [LEN_W-1:0] rd_len_reg;
    logic [REF_W-1:0] rd_ref_reg;

    logic             m_valid_reg;
    logic             m_kind_reg;
    logic [SEQ_W-1:0] m_seq_reg;
    logic [LEN_W-1:0] m_len_reg;
    logic [REF_W-1:0] m_ref_reg;
    logic             m_last_reg;

    logic [SEQ_W-1:0] seq_offset;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WIN_RESET;
        end else if (cfg_valid) begin
            window_reg <= cfg_data;
        end
    end

    // Sequence space is a power of two, so the modular distance is a wrap.
    assign seq_offset     = s_seq - next_exp_reg;
    assign stat.in_window = (seq_offset < window_reg);
    assign stat.head_held = flags_reg[next_exp_reg];
    assign stat.out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_seq_reg <= s_seq;
            in_len_reg <= (s_len > MAX_LEN) ? MAX_LEN : s_len;
            in_ref_reg <= s_ref;
        end
    end

    assign next_exp_next = cmd.deliver ? next_exp_reg + SEQ_W'(1) : next_exp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_exp_reg <= '0;
            flags_reg    <= '0;
        end else begin
            next_exp_reg <= next_exp_next;
            if (cmd.store) begin
                flags_reg[in_seq_reg] <= 1'b1;
            end
            if (cmd.deliver) begin
                flags_reg[next_exp_reg] <= 1'b0;
            end
        end
    end

    // Slot store; the read follows the counter so the next head is ready
    // the cycle after a delivery.
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            held_len_mem[in_seq_reg] <= in_len_reg;
            held_ref_mem[in_seq_reg] <= in_ref_reg;
        end
        rd_len_reg <= held_len_mem[next_exp_next];
        rd_ref_reg <= held_ref_mem[next_exp_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.deliver || cmd.ack) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.deliver) begin
            m_kind_reg <= KIND_DELIVER;
            m_seq_reg  <= next_exp_reg;
            m_len_reg  <= rd_len_reg;
            m_ref_reg  <= rd_ref_reg;
            m_last_reg <= 1'b0;
        end else if (cmd.ack) begin
            m_kind_reg <= KIND_ACK;
            m_seq_reg  <= next_exp_reg - SEQ_W'(1);
            m_len_reg  <= '0;
            m_ref_reg  <= '0;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_kind   = m_kind_reg;
    assign m_seq    = m_seq_reg;
    assign m_len    = m_len_reg;
    assign m_ref    = m_ref_reg;
    assign m_last   = m_last_reg;

endmodule

@@ design/reorder_receive_window_core.sv @@
`timescale 1ns / 1ps
// Top level of the reorder receive window: controller plus datapath.
// Depends on rrw_pkg, rrw_ctrl and rrw_datapath.
//
// Usage: the slave stream carries one verified data packet descriptor per
// item. A packet whose sequence number lies within window_size of the next
// expected sequence is stored in its slot (a repeat overwrites it); a packet
// outside the window is taken and dropped with no result. After a store the
// block emits every consecutive held packet from the next expected sequence
// as delivery items (tuser = 0, tlast = 0), then one cumulative ack item
// (tuser = 1, tlast = 1) for next expected minus one, sent even when nothing
// was delivered.
// Sequence: an accepted in-window packet passes through the store, fetch and
// deliver states, emitting its deliveries and then the ack, before the next
// packet can be accepted; the ack sits in the output register while the next
// packet is already taken. A dropped packet never leaves the idle state.
// Reset clears the received flags and the next expected sequence and sets
// the window to 4; the slot memory itself is not cleared. When the receiver
// stalls, the pending result holds on the master side and delivery waits.
// The configuration channel is always ready. The user must write it only
// while idle; the block itself does not enforce this.
module reorder_receive_window_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rrw_pkg::WIN_W-1:0]     cfg_data,     // window_size
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rrw_pkg::S_DATA_W-1:0]  s_tdata,      // seq, pkt_len, payload_ref
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rrw_pkg::M_DATA_W-1:0]  m_tdata,      // out_seq, out_len, out_ref
    output logic                          m_tuser,      // kind
    output logic                          m_tlast       // last
);
    import rrw_pkg::*;

    rrw_cmd_t         cmd;
    rrw_stat_t        stat;
    logic [SEQ_W-1:0] out_seq;
    logic [LEN_W-1:0] out_len;
    logic [REF_W-1:0] out_ref;

    // The window register can always be written.
    assign cfg_ready = 1'b1;

    rrw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_seq     (s_tdata[SEQ_W-1:0]),
        .s_len     (s_tdata[SEQ_W+LEN_W-1:SEQ_W]),
        .s_ref     (s_tdata[SEQ_W+LEN_W+REF_W-1:SEQ_W+LEN_W]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_kind    (m_tuser),
        .m_seq     (out_seq),
        .m_len     (out_len),
        .m_ref     (out_ref),
        .m_last    (m_tlast)
    );

    // Fields packed from the lowest bit up; the 48 bits fill six bytes.
    assign m_tdata = M_DATA_W'({out_ref, out_len, out_seq});

endmodule
